// ===== rtl/uetd_pkg.sv =====
// ----------------------------------------------------------------------------
// uetd_pkg: shared definitions for the echo-to-distance converter
// Widths, register codes and reset values, the temperature-to-pace table and
// the records passed between the top level and the pipelined divider.
// ----------------------------------------------------------------------------
package uetd_pkg;

    localparam int DISTANCE_LIMIT = 1023;

    localparam int ECHO_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int DIST_W  = 10;
    localparam int PACE_W  = 6;
    localparam int PACE2_W = PACE_W + 1;
    // Echo plus round-trip pace minus one.
    localparam int SUM_W   = ECHO_W + 1;
    // The smallest round-trip pace is 48, so the quotient stays below 2048.
    localparam int QUOT_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [TEMP_W-1:0] AIR_TEMP_RESET = TEMP_W'(20);
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(2);
    localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(400);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR_TEMP = 2'd0,
        CFG_MIN_DIST = 2'd1,
        CFG_MAX_DIST = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [PACE2_W-1:0] pace2;
        logic               nz;
    } t_div_in;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              nz;
    } t_div_out;

    // One-way sound pace in whole microseconds per centimetre, that is
    // floor(10000000 / (331300 + 606*t)). The pace falls by one at each
    // temperature edge below, so the table is kept as its breakpoints.
    function automatic logic [PACE_W-1:0] pace_of_temp(input logic signed [TEMP_W-1:0] t);
        logic [PACE_W-1:0] p;
        if      (t <= -124) p = 6'd39;
        else if (t <= -113) p = 6'd38;
        else if (t <= -101) p = 6'd37;
        else if (t <= -89)  p = 6'd36;
        else if (t <= -76)  p = 6'd35;
        else if (t <= -62)  p = 6'd34;
        else if (t <= -47)  p = 6'd33;
        else if (t <= -32)  p = 6'd32;
        else if (t <= -15)  p = 6'd31;
        else if (t <= 3)    p = 6'd30;
        else if (t <= 22)   p = 6'd29;
        else if (t <= 42)   p = 6'd28;
        else if (t <= 64)   p = 6'd27;
        else if (t <= 87)   p = 6'd26;
        else if (t <= 113)  p = 6'd25;
        else                p = 6'd24;
        return p;
    endfunction

endpackage

// ===== rtl/uetd_divider.sv =====
// ----------------------------------------------------------------------------
// uetd_divider: pipelined restoring divider
// Produces one quotient bit per stage, most significant first. Every stage
// holds its own valid bit and moves on when the stage after it has room.
// ----------------------------------------------------------------------------
module uetd_divider
    import uetd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_div_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_div_out o_out_data
);

    logic                 r_v    [QUOT_W];
    logic [SUM_W-1:0]     r_rem  [QUOT_W];
    logic [QUOT_W-1:0]    r_quot [QUOT_W];
    logic [PACE2_W-1:0]   r_div  [QUOT_W];
    logic                 r_nz   [QUOT_W];
    logic [QUOT_W:0]      w_ready;

    assign w_ready[QUOT_W] = i_out_ready;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;
        localparam logic [QUOT_W-1:0] MASK = QUOT_W'(1) << BIT;

        logic                 src_v;
        logic [SUM_W-1:0]     src_rem;
        logic [QUOT_W-1:0]    src_quot;
        logic [PACE2_W-1:0]   src_div;
        logic                 src_nz;
        logic [SUM_W:0]       trial;

        if (k == 0) begin : g_first
            assign src_v    = i_in_valid;
            assign src_rem  = i_in_data.sum;
            assign src_quot = '0;
            assign src_div  = i_in_data.pace2;
            assign src_nz   = i_in_data.nz;
        end else begin : g_next
            assign src_v    = r_v[k-1];
            assign src_rem  = r_rem[k-1];
            assign src_quot = r_quot[k-1];
            assign src_div  = r_div[k-1];
            assign src_nz   = r_nz[k-1];
        end

        // A borrow out of the top bit means the shifted divisor did not fit.
        assign trial = {1'b0, src_rem}
                     - ({{(SUM_W + 1 - PACE2_W){1'b0}}, src_div} << BIT);

        assign w_ready[k] = !r_v[k] || w_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_ready[k]) begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[k] && src_v) begin
                r_rem[k]  <= trial[SUM_W] ? src_rem : trial[SUM_W-1:0];
                r_quot[k] <= trial[SUM_W] ? src_quot : (src_quot | MASK);
                r_div[k]  <= src_div;
                r_nz[k]   <= src_nz;
            end
        end
    end

    assign o_in_ready  = w_ready[0];
    assign o_out_valid = r_v[QUOT_W-1];
    assign o_out_data  = '{quot: r_quot[QUOT_W-1], nz: r_nz[QUOT_W-1]};

endmodule

// ===== rtl/ultrasonic_echo_to_distance.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_to_distance: temperature-compensated echo-to-distance
// Turns an echo high time in microseconds into a distance in centimetres and
// checks it against the programmed limits.
// ----------------------------------------------------------------------------
// Usage:
// Echo times arrive on the input channel (i_in_valid / o_in_stall); a request
// is taken at a clock edge with i_in_valid high and o_in_stall low. Each one
// gives exactly one result on the output channel (o_out_valid / i_out_stall),
// in order. A result shows o_distance_cm and o_distance_valid; a timeout
// (zero echo) or a distance outside the limits gives valid 0 and distance 0.
// One request can be taken every cycle while o_in_stall is low. Each taken
// request passes one input stage that looks up the pace and forms the
// rounded-up dividend, eleven divider stages that each settle one quotient
// bit, and the output register with the limit check.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling up until each holds a request; only then is
// o_in_stall raised. The configuration port is a plain write port; the user
// must write it only while no request is in flight; the block does not enforce it.
// A synchronous reset empties the pipeline and loads temperature 20 C,
// minimum 2 cm and maximum 400 cm.
// ----------------------------------------------------------------------------
module ultrasonic_echo_to_distance
    import uetd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ECHO_W-1:0]     i_echo_time,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DIST_W-1:0]     o_distance_cm,
    output logic                  o_distance_valid
);

    localparam logic [SUM_W-1:0] LIMIT_EXT = SUM_W'(DISTANCE_LIMIT);

    logic [TEMP_W-1:0]  r_air_temp;
    logic [DIST_W-1:0]  r_min_dist;
    logic [DIST_W-1:0]  r_max_dist;

    logic               r_s0_v;
    t_div_in            r_s0;
    t_div_in            n_s0;
    logic               w_s0_ready;

    logic               w_div_in_ready;
    logic               w_div_v;
    t_div_out           w_div;
    logic               w_out_ready;

    logic [DIST_W-1:0]  w_lo;
    logic [DIST_W-1:0]  w_hi_raised;
    logic [DIST_W-1:0]  w_hi;
    logic               w_ok;

    logic               r_out_v;
    logic [DIST_W-1:0]  r_dist;
    logic               r_dist_ok;

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_temp <= AIR_TEMP_RESET;
            r_min_dist <= MIN_DIST_RESET;
            r_max_dist <= MAX_DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AIR_TEMP: r_air_temp <= i_cfg_data[TEMP_W-1:0];
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST: r_max_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: round-trip pace and the dividend that rounds the quotient up.
    always_comb begin
        n_s0.pace2 = {pace_of_temp(r_air_temp), 1'b0};
        n_s0.sum   = SUM_W'(i_echo_time) + SUM_W'(n_s0.pace2) - SUM_W'(1);
        n_s0.nz    = (i_echo_time != '0);
    end

    assign w_s0_ready = !r_s0_v || w_div_in_ready;
    assign o_in_stall = !w_s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_s0_ready) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_ready && i_in_valid) begin
            r_s0 <= n_s0;
        end
    end

    uetd_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_s0_v),
        .o_in_ready  (w_div_in_ready),
        .i_in_data   (r_s0),
        .o_out_valid (w_div_v),
        .i_out_ready (w_out_ready),
        .o_out_data  (w_div)
    );

    // Effective limits; the maximum is never below the minimum.
    always_comb begin
        w_lo = ({{(SUM_W - DIST_W){1'b0}}, r_min_dist} > LIMIT_EXT)
             ? LIMIT_EXT[DIST_W-1:0] : r_min_dist;
        w_hi_raised = (r_max_dist < w_lo) ? w_lo : r_max_dist;
        w_hi = ({{(SUM_W - DIST_W){1'b0}}, w_hi_raised} > LIMIT_EXT)
             ? LIMIT_EXT[DIST_W-1:0] : w_hi_raised;
        w_ok = w_div.nz
            && (w_div.quot >= QUOT_W'(w_lo))
            && (w_div.quot <= QUOT_W'(w_hi));
    end

    assign w_out_ready = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_ready) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_div_v) begin
            r_dist    <= w_ok ? w_div.quot[DIST_W-1:0] : '0;
            r_dist_ok <= w_ok;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_distance_cm    = r_dist;
    assign o_distance_valid = r_dist_ok;

`ifndef NO_ASSERTIONS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_valid_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_distance_valid)
        |-> (o_distance_cm >= w_lo) && (o_distance_cm <= w_hi))
        else $error("distance flagged valid outside the limits");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_distance_valid) |-> (o_distance_cm == '0))
        else $error("rejected distance is not zero");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s0_v && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");
`endif

endmodule
